/* sv/drive_command_decoder_with_watchdog_defines.svh */
// assertion macros shared by the drive command decoder modules
// no dependencies; taken in by `include where assertions are written
`ifndef DRIVE_COMMAND_DECODER_WITH_WATCHDOG_DEFINES_SVH
`define DRIVE_COMMAND_DECODER_WITH_WATCHDOG_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DCDW_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define DCDW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/dcdw_pkg.sv */
// types, constants and character codes of the drive command decoder
// no dependencies
package dcdw_pkg;

   localparam int TIMEOUT_W = 16;
   localparam int ELAPSED_W = 17;
   localparam int SPEED_W   = 8;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1500;
   localparam logic [SPEED_W-1:0]   SPEED_RESET   = 8'd200;
   localparam logic [SPEED_W-1:0]   SPEED_STEP    = 8'd25;
   localparam logic [SPEED_W-1:0]   SPEED_MAX     = 8'd255;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = 17'h1FFFF;

   // command characters
   localparam logic [7:0] CH_F = 8'h46;
   localparam logic [7:0] CH_B = 8'h42;
   localparam logic [7:0] CH_L = 8'h4C;
   localparam logic [7:0] CH_R = 8'h52;
   localparam logic [7:0] CH_G = 8'h47;
   localparam logic [7:0] CH_I = 8'h49;
   localparam logic [7:0] CH_H = 8'h48;
   localparam logic [7:0] CH_J = 8'h4A;
   localparam logic [7:0] CH_S = 8'h53;
   localparam logic [7:0] CH_X = 8'h58;
   localparam logic [7:0] CH_0 = 8'h30;
   localparam logic [7:0] CH_9 = 8'h39;
   localparam logic [7:0] CH_Q_LOWER = 8'h71;
   localparam logic [7:0] CH_A_LOWER = 8'h61;
   localparam logic [7:0] CH_Z_LOWER = 8'h7A;
   localparam logic [7:0] CASE_MASK  = 8'hDF;

   typedef enum logic [3:0] {
      MOT_STOP       = 4'd0,
      MOT_FWD        = 4'd1,
      MOT_BACK       = 4'd2,
      MOT_LEFT       = 4'd3,
      MOT_RIGHT      = 4'd4,
      MOT_FWD_LEFT   = 4'd5,
      MOT_FWD_RIGHT  = 4'd6,
      MOT_BACK_LEFT  = 4'd7,
      MOT_BACK_RIGHT = 4'd8
   } motion_type;

   typedef enum logic [1:0] {
      CMD_NONE   = 2'd0,
      CMD_MOTION = 2'd1,
      CMD_SPEED  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      motion_type          motion;
      logic [SPEED_W-1:0]  speed;
   } cmd_type;

   typedef struct packed {
      motion_type          motion;
      logic [SPEED_W-1:0]  speed;
      logic                fired;
   } upd_type;

   typedef struct packed {
      logic [SPEED_W-1:0] left_fwd;
      logic [SPEED_W-1:0] left_rev;
      logic [SPEED_W-1:0] right_fwd;
      logic [SPEED_W-1:0] right_rev;
   } duty_type;

endpackage

/* sv/dcdw_req_if.sv */
// request channel: one command byte or tick per beat
// depends on nothing
interface dcdw_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] command_byte;

   modport source (output valid, output func, output command_byte, input ready);
   modport sink   (input valid, input func, input command_byte, output ready);
endinterface

/* sv/dcdw_rsp_if.sv */
// response channel: bridge duties, motion and safety stop flag per beat
// depends on nothing
interface dcdw_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] left_fwd_duty;
   logic [7:0] left_rev_duty;
   logic [7:0] right_fwd_duty;
   logic [7:0] right_rev_duty;
   logic [3:0] motion;
   logic       timeout_stop;

   modport source (output valid, output left_fwd_duty, output left_rev_duty,
                   output right_fwd_duty, output right_rev_duty, output motion,
                   output timeout_stop, input ready);
   modport sink   (input valid, input left_fwd_duty, input left_rev_duty,
                   input right_fwd_duty, input right_rev_duty, input motion,
                   input timeout_stop, output ready);
endinterface

/* sv/dcdw_decode.sv */
// command byte decoder: motion letters, speed digits and 'q'
// depends on dcdw_pkg
module dcdw_decode (
   input  logic [7:0]       command_byte,
   output dcdw_pkg::cmd_type cmd
);

   logic [7:0] upper;
   logic       is_digit;

   always_comb begin
      if (command_byte >= dcdw_pkg::CH_A_LOWER && command_byte <= dcdw_pkg::CH_Z_LOWER) begin
         upper = command_byte & dcdw_pkg::CASE_MASK;
      end else begin
         upper = command_byte;
      end
      is_digit = (command_byte >= dcdw_pkg::CH_0) && (command_byte <= dcdw_pkg::CH_9);

      cmd.kind   = dcdw_pkg::CMD_MOTION;
      cmd.motion = dcdw_pkg::MOT_STOP;
      cmd.speed  = dcdw_pkg::SPEED_MAX;

      unique case (upper) inside
         dcdw_pkg::CH_S, dcdw_pkg::CH_X: cmd.motion = dcdw_pkg::MOT_STOP;
         dcdw_pkg::CH_F: cmd.motion = dcdw_pkg::MOT_FWD;
         dcdw_pkg::CH_B: cmd.motion = dcdw_pkg::MOT_BACK;
         dcdw_pkg::CH_L: cmd.motion = dcdw_pkg::MOT_LEFT;
         dcdw_pkg::CH_R: cmd.motion = dcdw_pkg::MOT_RIGHT;
         dcdw_pkg::CH_G: cmd.motion = dcdw_pkg::MOT_FWD_LEFT;
         dcdw_pkg::CH_I: cmd.motion = dcdw_pkg::MOT_FWD_RIGHT;
         dcdw_pkg::CH_H: cmd.motion = dcdw_pkg::MOT_BACK_LEFT;
         dcdw_pkg::CH_J: cmd.motion = dcdw_pkg::MOT_BACK_RIGHT;
         default: begin
            if (is_digit) begin
               // digit times 25 fits in eight bits
               cmd.kind  = dcdw_pkg::CMD_SPEED;
               cmd.speed = 8'({4'd0, command_byte[3:0]} * dcdw_pkg::SPEED_STEP);
            end else if (command_byte == dcdw_pkg::CH_Q_LOWER) begin
               cmd.kind  = dcdw_pkg::CMD_SPEED;
            end else begin
               cmd.kind  = dcdw_pkg::CMD_NONE;
            end
         end
      endcase
   end

endmodule

/* sv/dcdw_state.sv */
// motion, speed and elapsed-time registers with the watchdog compare
// depends on dcdw_pkg and the assertion macro header
`include "drive_command_decoder_with_watchdog_defines.svh"

module dcdw_state (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  logic                               func,
   input  dcdw_pkg::cmd_type                  cmd,
   input  logic [dcdw_pkg::TIMEOUT_W-1:0]     timeout_ms,
   output dcdw_pkg::upd_type                  upd
);

   dcdw_pkg::motion_type               motion_ff, motion_in;
   logic [dcdw_pkg::SPEED_W-1:0]       speed_ff, speed_in;
   logic [dcdw_pkg::ELAPSED_W-1:0]     elapsed_ff, elapsed_in;
   logic [dcdw_pkg::ELAPSED_W-1:0]     elapsed_inc;
   logic                               fire;

   always_comb begin
      motion_in  = motion_ff;
      speed_in   = speed_ff;
      elapsed_in = elapsed_ff;
      fire       = 1'b0;

      // saturating millisecond count
      if (elapsed_ff != dcdw_pkg::ELAPSED_MAX) begin
         elapsed_inc = elapsed_ff + 1'b1;
      end else begin
         elapsed_inc = elapsed_ff;
      end

      if (func) begin
         elapsed_in = elapsed_inc;
         if (timeout_ms != '0 && motion_ff != dcdw_pkg::MOT_STOP &&
             elapsed_inc > {1'b0, timeout_ms}) begin
            motion_in  = dcdw_pkg::MOT_STOP;
            elapsed_in = '0;
            fire       = 1'b1;
         end
      end else begin
         unique case (cmd.kind)
            dcdw_pkg::CMD_MOTION: begin
               motion_in  = cmd.motion;
               elapsed_in = '0;
            end
            dcdw_pkg::CMD_SPEED: begin
               speed_in   = cmd.speed;
               elapsed_in = '0;
            end
            default: ;
         endcase
      end

      upd.motion = motion_in;
      upd.speed  = speed_in;
      upd.fired  = fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motion_ff  <= dcdw_pkg::MOT_STOP;
         speed_ff   <= dcdw_pkg::SPEED_RESET;
         elapsed_ff <= '0;
      end else if (step) begin
         motion_ff  <= motion_in;
         speed_ff   <= speed_in;
         elapsed_ff <= elapsed_in;
      end
   end

   `DCDW_ASSERT_NEXT(a_fire_stops, clock, reset, step && fire,
      motion_ff == dcdw_pkg::MOT_STOP && elapsed_ff == '0, "safety stop left state moving")
   `DCDW_ASSERT_IMPL(a_fire_on_tick, clock, reset, step && fire,
      func && timeout_ms != '0, "safety stop without tick or with watchdog off")
   `DCDW_ASSERT_NEXT(a_hold_idle, clock, reset, !step,
      $stable(motion_ff) && $stable(elapsed_ff), "state moved without a beat")

endmodule

/* sv/dcdw_duty.sv */
// maps motion and speed to the four bridge duties
// depends on dcdw_pkg
module dcdw_duty (
   input  dcdw_pkg::motion_type           motion,
   input  logic [dcdw_pkg::SPEED_W-1:0]   speed,
   output dcdw_pkg::duty_type             duty
);

   logic [dcdw_pkg::SPEED_W-1:0] half;

   always_comb begin
      half = speed >> 1;
      duty = '0;
      unique case (motion)
         dcdw_pkg::MOT_FWD: begin
            duty.left_fwd  = speed;
            duty.right_fwd = speed;
         end
         dcdw_pkg::MOT_BACK: begin
            duty.left_rev  = speed;
            duty.right_rev = speed;
         end
         dcdw_pkg::MOT_LEFT: begin
            duty.left_rev  = speed;
            duty.right_fwd = speed;
         end
         dcdw_pkg::MOT_RIGHT: begin
            duty.left_fwd  = speed;
            duty.right_rev = speed;
         end
         dcdw_pkg::MOT_FWD_LEFT: begin
            duty.left_fwd  = half;
            duty.right_fwd = speed;
         end
         dcdw_pkg::MOT_FWD_RIGHT: begin
            duty.left_fwd  = speed;
            duty.right_fwd = half;
         end
         dcdw_pkg::MOT_BACK_LEFT: begin
            duty.left_rev  = half;
            duty.right_rev = speed;
         end
         dcdw_pkg::MOT_BACK_RIGHT: begin
            duty.left_rev  = speed;
            duty.right_rev = half;
         end
         default: duty = '0;
      endcase
   end

endmodule

/* sv/drive_command_decoder_with_watchdog.sv */
// channel   dir  handshake      payload
// req_bus   in   valid/ready    func, command_byte
// rsp_bus   out  valid/ready    four duties, motion, timeout_stop
// csr_*     in   csr_wr_en      csr_wr_data = timeout_ms
//
// one beat per cycle sustained while rsp_bus is ready; a beat taken sits in the
// input register, is processed into the response register once that is free or
// read, then leaves from it; the state update and duty map sit between the two.
// synchronous reset: motion stop, speed 200, elapsed 0, timeout 1500.
// a stalled response holds; the input register still takes one more beat.
// depends on dcdw_pkg, dcdw_req_if, dcdw_rsp_if, dcdw_decode, dcdw_state,
// dcdw_duty and the assertion macro header
`include "drive_command_decoder_with_watchdog_defines.svh"

module drive_command_decoder_with_watchdog (
   input  logic                           clock,
   input  logic                           reset,
   dcdw_req_if.sink                       req_bus,
   dcdw_rsp_if.source                     rsp_bus,
   input  logic                           csr_wr_en,
   input  logic [dcdw_pkg::TIMEOUT_W-1:0] csr_wr_data
);

   logic                               in_valid_ff, in_valid_in;
   logic                               in_func_ff;
   logic [7:0]                         in_byte_ff;
   logic                               out_valid_ff, out_valid_in;
   dcdw_pkg::duty_type                 duty_ff;
   dcdw_pkg::motion_type               motion_ff;
   logic                               stop_ff;
   logic [dcdw_pkg::TIMEOUT_W-1:0]     timeout_ff;

   logic                               take;
   logic                               advance;
   dcdw_pkg::cmd_type                  cmd;
   dcdw_pkg::upd_type                  upd;
   dcdw_pkg::duty_type                 duty;

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   dcdw_decode u_decode (
      .command_byte (in_byte_ff),
      .cmd          (cmd)
   );

   dcdw_state u_state (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .func       (in_func_ff),
      .cmd        (cmd),
      .timeout_ms (timeout_ff),
      .upd        (upd)
   );

   dcdw_duty u_duty (
      .motion (upd.motion),
      .speed  (upd.speed),
      .duty   (duty)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         timeout_ff   <= dcdw_pkg::TIMEOUT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         in_func_ff <= req_bus.func;
         in_byte_ff <= req_bus.command_byte;
      end
      if (advance) begin
         duty_ff   <= duty;
         motion_ff <= upd.motion;
         stop_ff   <= upd.fired;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.left_fwd_duty  = duty_ff.left_fwd;
   assign rsp_bus.left_rev_duty  = duty_ff.left_rev;
   assign rsp_bus.right_fwd_duty = duty_ff.right_fwd;
   assign rsp_bus.right_rev_duty = duty_ff.right_rev;
   assign rsp_bus.motion         = motion_ff;
   assign rsp_bus.timeout_stop   = stop_ff;

   `DCDW_ASSERT_NEXT(a_adv_fills_rsp, clock, reset, advance, out_valid_ff,
      "processed beat did not reach the response register")
   `DCDW_ASSERT_IMPL(a_left_exclusive, clock, reset, out_valid_ff,
      duty_ff.left_fwd == '0 || duty_ff.left_rev == '0, "left bridge driven both ways")
   `DCDW_ASSERT_IMPL(a_stop_zero_duty, clock, reset, out_valid_ff && stop_ff,
      duty_ff == '0 && motion_ff == dcdw_pkg::MOT_STOP, "safety stop with nonzero duty")

endmodule

/* test/tb.sv */
// self-checking testbench for the drive command decoder with its command watchdog
// uses dcdw_pkg, dcdw_req_if and dcdw_rsp_if; a scoreboard class predicts duties per beat
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dcdw_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      duty_type   duties;
      logic [3:0] motion;
      logic       timeout_stop;
   } drive_result;

   class duty_scoreboard;
      motion_type           cur_motion;
      logic [SPEED_W-1:0]   cur_speed;
      logic [ELAPSED_W-1:0] elapsed_ms;
      logic [TIMEOUT_W-1:0] timeout_ms;
      drive_result          expected_duties[$];
      int                   mismatches;

      function new();
         cur_motion = MOT_STOP;
         cur_speed  = SPEED_RESET;
         elapsed_ms = '0;
         timeout_ms = TIMEOUT_RESET;
         mismatches = 0;
      endfunction

      function bit letter_to_motion(input logic [7:0] ch, output motion_type m);
         logic [7:0] up;
         up = (ch >= CH_A_LOWER && ch <= CH_Z_LOWER) ? (ch & CASE_MASK) : ch;
         letter_to_motion = 1'b1;
         case (up)
            CH_S, CH_X: m = MOT_STOP;
            CH_F: m = MOT_FWD;
            CH_B: m = MOT_BACK;
            CH_L: m = MOT_LEFT;
            CH_R: m = MOT_RIGHT;
            CH_G: m = MOT_FWD_LEFT;
            CH_I: m = MOT_FWD_RIGHT;
            CH_H: m = MOT_BACK_LEFT;
            CH_J: m = MOT_BACK_RIGHT;
            default: begin
               m = MOT_STOP;
               letter_to_motion = 1'b0;
            end
         endcase
      endfunction

      function duty_type duty_map(input motion_type m, input logic [SPEED_W-1:0] s);
         logic [SPEED_W-1:0] h;
         duty_type d;
         h = s >> 1;
         d = '0;
         case (m)
            MOT_FWD: begin
               d.left_fwd = s;
               d.right_fwd = s;
            end
            MOT_BACK: begin
               d.left_rev = s;
               d.right_rev = s;
            end
            MOT_LEFT: begin
               d.left_rev = s;
               d.right_fwd = s;
            end
            MOT_RIGHT: begin
               d.left_fwd = s;
               d.right_rev = s;
            end
            MOT_FWD_LEFT: begin
               d.left_fwd = h;
               d.right_fwd = s;
            end
            MOT_FWD_RIGHT: begin
               d.left_fwd = s;
               d.right_fwd = h;
            end
            MOT_BACK_LEFT: begin
               d.left_rev = h;
               d.right_rev = s;
            end
            MOT_BACK_RIGHT: begin
               d.left_rev = s;
               d.right_rev = h;
            end
            default: ;
         endcase
         return d;
      endfunction

      function void note_beat(input logic is_tick, input logic [7:0] ch);
         motion_type  m;
         drive_result r;
         logic        fired;
         fired = 1'b0;
         if (is_tick) begin
            if (elapsed_ms != ELAPSED_MAX) elapsed_ms = elapsed_ms + 1'b1;
            if (timeout_ms != '0 && cur_motion != MOT_STOP &&
                elapsed_ms > {1'b0, timeout_ms}) begin
               cur_motion = MOT_STOP;
               elapsed_ms = '0;
               fired = 1'b1;
            end
         end else if (letter_to_motion(ch, m)) begin
            cur_motion = m;
            elapsed_ms = '0;
         end else if (ch >= CH_0 && ch <= CH_9) begin
            cur_speed = (ch - CH_0) * SPEED_STEP;
            elapsed_ms = '0;
         end else if (ch == CH_Q_LOWER) begin
            cur_speed = SPEED_MAX;
            elapsed_ms = '0;
         end
         r.duties = duty_map(cur_motion, cur_speed);
         r.motion = cur_motion;
         r.timeout_stop = fired;
         expected_duties.push_back(r);
      endfunction

      function void check_beat(input drive_result got);
         drive_result want;
         if (expected_duties.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response beat: duties %h %h %h %h motion %0d stop %0b",
                        got.duties.left_fwd, got.duties.left_rev, got.duties.right_fwd,
                        got.duties.right_rev, got.motion, got.timeout_stop);
            return;
         end
         want = expected_duties.pop_front();
         if (got.duties.left_fwd !== want.duties.left_fwd ||
             got.duties.left_rev !== want.duties.left_rev ||
             got.duties.right_fwd !== want.duties.right_fwd ||
             got.duties.right_rev !== want.duties.right_rev ||
             got.motion !== want.motion || got.timeout_stop !== want.timeout_stop) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display({"mismatch: expected duties %h %h %h %h motion %0d stop %0b, ",
                         "got duties %h %h %h %h motion %0d stop %0b"},
                        want.duties.left_fwd, want.duties.left_rev, want.duties.right_fwd,
                        want.duties.right_rev, want.motion, want.timeout_stop,
                        got.duties.left_fwd, got.duties.left_rev, got.duties.right_fwd,
                        got.duties.right_rev, got.motion, got.timeout_stop);
         end
      endfunction

      function int pending();
         return expected_duties.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [TIMEOUT_W-1:0] csr_wr_data;
   int                   send_idle_pct;
   int                   rcv_idle_pct;
   int                   stall_cycles = 0;
   duty_scoreboard       board;

   dcdw_req_if req ();
   dcdw_rsp_if rsp ();

   drive_command_decoder_with_watchdog dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req),
      .rsp_bus     (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // returns in the step of the edge that took the beat, valid still high
   task automatic send_beat(input logic is_tick, input logic [7:0] ch);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.func <= is_tick;
      req.command_byte <= ch;
      do @(posedge clock); while (!req.ready);
      board.note_beat(is_tick, ch);
   endtask

   task automatic send_tick();
      send_beat(1'b1, 8'($urandom));
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      board.timeout_ms = value;
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [7:0] motion_letter(input bit allow_stop);
      logic [7:0] l;
      case ($urandom_range(allow_stop ? 9 : 7))
         0: l = CH_F;
         1: l = CH_B;
         2: l = CH_L;
         3: l = CH_R;
         4: l = CH_G;
         5: l = CH_I;
         6: l = CH_H;
         7: l = CH_J;
         8: l = CH_S;
         default: l = CH_X;
      endcase
      return $urandom_range(1) ? (l | ~CASE_MASK) : l;
   endfunction

   function automatic logic [7:0] speed_command();
      case ($urandom_range(5))
         0: return CH_Q_LOWER;
         1: return CH_Q_LOWER & CASE_MASK;
         default: return CH_0 + 8'($urandom_range(9));
      endcase
   endfunction

   // mostly drive-then-wait sequences so the watchdog gets reached, plus stray beats
   task automatic run_random(input int count);
      int sent;
      int run_len;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(9) < 6) begin
            send_beat(1'b0, motion_letter($urandom_range(7) == 0));
            sent++;
            if ($urandom_range(2) == 0) begin
               send_beat(1'b0, speed_command());
               sent++;
            end
            run_len = (board.timeout_ms == '0) ? $urandom_range(12)
                                               : $urandom_range(int'(board.timeout_ms) + 2);
            repeat (run_len) begin
               send_tick();
               sent++;
            end
         end else begin
            case ($urandom_range(3))
               0: begin
                  send_tick();
                  sent++;
               end
               1: begin
                  send_beat(1'b0, speed_command());
                  sent++;
               end
               default: send_beat(1'b0, 8'($urandom));
            endcase
         end
      end
   endtask

   function automatic logic [TIMEOUT_W-1:0] pick_timeout();
      case ($urandom_range(5))
         0: return '0;
         1: return 16'd1;
         default: return 16'($urandom_range(2, 40));
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == STALL_LIMIT) begin
            $display("drive_command_decoder_with_watchdog test failed");
            $finish;
         end
      end
   end

   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready)
            board.check_beat({rsp.left_fwd_duty, rsp.left_rev_duty, rsp.right_fwd_duty,
                              rsp.right_rev_duty, rsp.motion, rsp.timeout_stop});
         rsp.ready <= !(rcv_idle_pct != 0 && $urandom_range(99) < rcv_idle_pct);
      end
   end

   initial begin
      reset = 1'b1;
      req.valid = 1'b0;
      req.func = 1'b0;
      req.command_byte = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      send_idle_pct = 33;
      rcv_idle_pct = 65;
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset timeout; speed while stopped, every letter, odd speed halving, ignored bytes
      send_beat(1'b0, CH_0 + 8'd5);
      send_beat(1'b0, CH_F);
      send_beat(1'b0, CH_B | ~CASE_MASK);
      send_beat(1'b0, CH_L);
      send_beat(1'b0, CH_R | ~CASE_MASK);
      send_beat(1'b0, CH_G);
      send_beat(1'b0, CH_I | ~CASE_MASK);
      send_beat(1'b0, CH_H);
      send_beat(1'b0, CH_J | ~CASE_MASK);
      send_beat(1'b0, CH_X | ~CASE_MASK);
      send_beat(1'b0, CH_9);
      send_beat(1'b0, CH_I);
      send_beat(1'b0, CH_0 + 8'd3);
      send_beat(1'b0, CH_Q_LOWER);
      send_beat(1'b0, CH_Q_LOWER & CASE_MASK);
      send_beat(1'b0, 8'h00);
      send_beat(1'b0, 8'hFF);
      send_tick();
      send_beat(1'b0, CH_S);
      drain();

      // short timeout: stop fires on the tick that passes it, not again while stopped
      write_timeout(16'd2);
      send_beat(1'b0, CH_J);
      repeat (4) send_tick();
      drain();

      // watchdog disabled
      write_timeout('0);
      send_beat(1'b0, CH_F | ~CASE_MASK);
      repeat (2) send_tick();

      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 33 : (mode == 1) ? 65 : 0;
         rcv_idle_pct = (mode == 0) ? 65 : (mode == 1) ? 33 : 0;
         repeat (5) begin
            drain();
            write_timeout(pick_timeout());
            run_random(110);
         end
      end

      // largest timeout holds the motion through a short run of ticks
      drain();
      write_timeout(16'hFFFF);
      send_beat(1'b0, CH_F);
      repeat (8) send_tick();

      drain();
      if (board.mismatches == 0) begin
         $display("drive_command_decoder_with_watchdog test passed");
      end else begin
         $display("drive_command_decoder_with_watchdog test failed");
      end
      $finish;
   end
endmodule

/* filelist.f */
+incdir+sv
sv/dcdw_pkg.sv
sv/dcdw_req_if.sv
sv/dcdw_rsp_if.sv
sv/dcdw_decode.sv
sv/dcdw_state.sv
sv/dcdw_duty.sv
sv/drive_command_decoder_with_watchdog.sv
test/tb.sv
